// ===== rtl/prefix_cache_token_cost_top_defines.svh =====
// Assertion macros for the prefix cache token cost block.
// Used by the checker bound to the top level; depends on nothing else.
`ifndef PREFIX_CACHE_TOKEN_COST_TOP_DEFINES_SVH
`define PREFIX_CACHE_TOKEN_COST_TOP_DEFINES_SVH

// Condition a implies condition c in the same cycle.
`define PCC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pcc same-cycle check failed");

// Condition a implies condition c in the next cycle.
`define PCC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pcc next-cycle check failed");

`endif

// ===== rtl/pcc_pkg.sv =====
// Shared types, constants and helpers for the prefix cache token cost block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package pcc_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int KEY_W           = 26;
    localparam int WORD_W          = KEY_W + 2;
    localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

    localparam logic [1:0] CHOICE_LITERAL = 2'd0;
    localparam logic [1:0] CHOICE_CACHE   = 2'd1;
    localparam logic [1:0] CHOICE_PREV    = 2'd2;

    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_PREV_ENABLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_INC,
        ST_INS2,
        ST_INS3,
        ST_SW_RD,
        ST_SW_EV,
        ST_DONE
    } pcc_state_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_cmp;
        logic decide;
        logic inc_wr;
        logic ins_sel3;
        logic ins_direct;
        logic sw_rd;
        logic sw_ev;
        logic finish;
    } pcc_cmd_t;

    typedef struct packed {
        logic scan_more;
        logic need2;
        logic need3;
        logic full;
        logic sw_zero;
        logic pick_cache;
        logic out_free;
    } pcc_status_t;

    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        unique case (n)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/prefix_cache_token_cost_top.sv =====
// Top level of the prefix cache token cost block: configuration registers,
// controller and datapath. Depends on pcc_pkg, pcc_ctrl and pcc_datapath.
//
//   Channel | Direction | Handshake        | Content
//   s_*     | in        | tvalid / tready  | one token per beat
//   m_*     | out       | tvalid / tready  | one cost result per beat
//   APB     | in        | psel / penable   | capacity at 0x0, prev enable at 0x4
//
// A result is registered once its token is taken and the filled entries are
// scanned (none for tokens shorter than three bytes), one per read and compare
// step of the single-port entry memory; then the next token can be taken.
// Picking a cache entry adds a step. Each replacement adds an evict step, plus
// a read and an evict step for every scored entry the CLOCK hand ages on its
// way. Reset is asynchronous and active low; the entry memory is not cleared,
// the fill count bounds every read. A result waits in the output register
// while the next token is already taken; a stalled output holds the block only
// at the point where it would hand over the next result.
`default_nettype none

module prefix_cache_token_cost_top #(
    parameter int MAX_ENTRIES = pcc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tdata: token_bytes [31:0], token_len [34:32], zero padding [39:35]
    input  wire logic [39:0] s_tdata,
    // tuser: region_start [0]
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: cost_bits [5:0], cache_hit [6], match_len [8:7], region_bits [28:9],
    // zero padding [31:29]
    output logic [31:0]      m_tdata,
    // tuser: choice [1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    pcc_pkg::pcc_cmd_t    cmd;
    pcc_pkg::pcc_status_t status;

    logic [8:0] capacity_reg;
    logic       prev_enable_reg;
    logic [5:0] cost;
    logic [1:0] choice;
    logic       hit;
    logic [1:0] mlen;
    logic [19:0] total;

    assign pready = 1'b1;

    // Register writes complete in the access phase; the word address bit
    // selects the register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= 9'd256;
            prev_enable_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == pcc_pkg::REG_CAPACITY)
                capacity_reg <= pwdata[8:0];
            else
                prev_enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == pcc_pkg::REG_PREV_ENABLE) ? {31'd0, prev_enable_reg}
                                                           : {23'd0, capacity_reg};

    pcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .capacity_cfg      (capacity_reg),
        .prev_match_enable (prev_enable_reg),
        .in_bytes          (s_tdata[31:0]),
        .in_len            (s_tdata[34:32]),
        .in_region_start   (s_tuser),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_cost          (cost),
        .out_choice        (choice),
        .out_hit           (hit),
        .out_mlen          (mlen),
        .out_total         (total)
    );

    assign m_tdata = {3'd0, total, mlen, hit, cost};
    assign m_tuser = choice;

endmodule

`default_nettype wire

// ===== rtl/pcc_ctrl.sv =====
// Sequencing state machine for the prefix cache token cost block.
// Depends on pcc_pkg for the state, command and status types.
`default_nettype none

module pcc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pcc_pkg::pcc_status_t status,
    output pcc_pkg::pcc_cmd_t        cmd
);

    pcc_pkg::pcc_state_t state_reg, state_next;
    logic phase3_reg, phase3_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pcc_pkg::ST_IDLE;
            phase3_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase3_reg <= phase3_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase3_next = phase3_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            pcc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = pcc_pkg::ST_SCAN_RD;
                end
            end
            pcc_pkg::ST_SCAN_RD:
            begin
                if (status.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = pcc_pkg::ST_SCAN_CMP;
                end
                else
                begin
                    state_next = pcc_pkg::ST_DECIDE;
                end
            end
            pcc_pkg::ST_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next   = pcc_pkg::ST_SCAN_RD;
            end
            pcc_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.pick_cache ? pcc_pkg::ST_INC : pcc_pkg::ST_INS2;
            end
            pcc_pkg::ST_INC:
            begin
                cmd.inc_wr = 1'b1;
                state_next = pcc_pkg::ST_INS2;
            end
            pcc_pkg::ST_INS2:
            begin
                phase3_next = 1'b0;
                if (!status.need2)
                begin
                    state_next = pcc_pkg::ST_INS3;
                end
                else if (!status.full)
                begin
                    cmd.ins_direct = 1'b1;
                    state_next     = pcc_pkg::ST_INS3;
                end
                else
                begin
                    cmd.sw_rd  = 1'b1;
                    state_next = pcc_pkg::ST_SW_EV;
                end
            end
            pcc_pkg::ST_INS3:
            begin
                phase3_next  = 1'b1;
                cmd.ins_sel3 = 1'b1;
                if (!status.need3)
                begin
                    state_next = pcc_pkg::ST_DONE;
                end
                else if (!status.full)
                begin
                    cmd.ins_direct = 1'b1;
                    state_next     = pcc_pkg::ST_DONE;
                end
                else
                begin
                    cmd.sw_rd  = 1'b1;
                    state_next = pcc_pkg::ST_SW_EV;
                end
            end
            pcc_pkg::ST_SW_RD:
            begin
                cmd.ins_sel3 = phase3_reg;
                cmd.sw_rd    = 1'b1;
                state_next   = pcc_pkg::ST_SW_EV;
            end
            pcc_pkg::ST_SW_EV:
            begin
                cmd.ins_sel3 = phase3_reg;
                cmd.sw_ev    = 1'b1;
                if (status.sw_zero)
                    state_next = phase3_reg ? pcc_pkg::ST_DONE : pcc_pkg::ST_INS3;
                else
                    state_next = pcc_pkg::ST_SW_RD;
            end
            pcc_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = pcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pcc_datapath.sv =====
// Datapath of the prefix cache token cost block: entry memory, scan,
// cost selection, CLOCK replacement and the output register.
// Depends on pcc_pkg; driven by pcc_ctrl through command and status structs.
`default_nettype none

module pcc_datapath #(
    parameter int MAX_ENTRIES = pcc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pcc_pkg::pcc_cmd_t    cmd,
    output pcc_pkg::pcc_status_t      status,
    input  wire logic [8:0]           capacity_cfg,
    input  wire logic                 prev_match_enable,
    input  wire logic [31:0]          in_bytes,
    input  wire logic [2:0]           in_len,
    input  wire logic                 in_region_start,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [5:0]                out_cost,
    output logic [1:0]                out_choice,
    output logic                      out_hit,
    output logic [1:0]                out_mlen,
    output logic [19:0]               out_total
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int WW = pcc_pkg::WORD_W;
    localparam int KW = pcc_pkg::KEY_W;

    logic [WW-1:0] mem [MAX_ENTRIES];
    logic [WW-1:0] rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    // Control state
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] hand_reg, hand_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [19:0]   total_reg, total_next;
    logic          out_valid_reg, out_valid_next;
    logic          found2_reg, found2_next;
    logic          found3_reg, found3_next;

    // Payload
    logic [31:0]   bytes_reg;
    logic [2:0]    n_reg;
    logic [31:0]   prev_tok_reg;
    logic [2:0]    prev_len_reg;
    logic [AW-1:0] idx2_reg, idx3_reg;
    logic [1:0]    sc2_reg, sc3_reg;
    logic [5:0]    best_reg;
    logic [1:0]    choice_reg;
    logic          hit_reg;
    logic [1:0]    mlen_reg;
    logic [5:0]    o_cost_reg;
    logic [1:0]    o_choice_reg;
    logic          o_hit_reg;
    logic [1:0]    o_mlen_reg;
    logic [19:0]   o_total_reg;

    logic [CW-1:0] cap;
    logic [2:0]    n_in;
    logic [KW-1:0] key2, key3, ins_key;
    logic          act2, act3;
    logic [AW-1:0] hand_eff, hand_adv;
    logic [5:0]    lit_cost, c_cost, p_cost, best_c;
    logic [1:0]    choice_c, mlen_c, clen, plen;
    logic          hit_c, p3, p2;
    logic [20:0]   total_sum;

    always_comb
    begin
        if (capacity_cfg == 9'd0)
            cap = CW'(1);
        else if (32'(capacity_cfg) > MAX_ENTRIES)
            cap = CW'(MAX_ENTRIES);
        else
            cap = CW'(capacity_cfg);
    end

    always_comb
    begin
        if (in_len == 3'd0)
            n_in = 3'd1;
        else if (in_len > 3'd4)
            n_in = 3'd4;
        else
            n_in = in_len;
    end

    assign key3    = {2'd3, bytes_reg[23:0]};
    assign key2    = {2'd2, 8'd0, bytes_reg[15:0]};
    assign act3    = (n_reg == 3'd4);
    assign act2    = (n_reg >= 3'd3);
    assign ins_key = cmd.ins_sel3 ? key3 : key2;

    assign hand_eff = (CW'(hand_reg) >= cap) ? '0 : hand_reg;
    assign hand_adv = ((CW'(hand_reg) + CW'(1)) >= cap) ? '0 : hand_reg + AW'(1);

    // Cost selection
    always_comb
    begin
        clen     = found3_reg ? 2'd3 : 2'd2;
        hit_c    = found3_reg || found2_reg;
        lit_cost = 6'd1 + {n_reg, 3'b000};
        c_cost   = 6'd10 + {n_reg - 3'(clen), 3'b000};
        p3 = (n_reg == 3'd4) && (prev_len_reg >= 3'd3) &&
             (bytes_reg[23:0] == prev_tok_reg[23:0]);
        p2 = (n_reg >= 3'd3) && (prev_len_reg >= 3'd2) &&
             (bytes_reg[15:0] == prev_tok_reg[15:0]);
        plen     = p3 ? 2'd3 : (p2 ? 2'd2 : 2'd0);
        p_cost   = 6'd3 + {n_reg - 3'(plen), 3'b000};
        best_c   = lit_cost;
        choice_c = pcc_pkg::CHOICE_LITERAL;
        mlen_c   = 2'd0;
        if (hit_c && (c_cost <= best_c))
        begin
            best_c   = c_cost;
            choice_c = pcc_pkg::CHOICE_CACHE;
            mlen_c   = clen;
        end
        if (prev_valid_reg && prev_match_enable && (plen != 2'd0) && (p_cost < best_c))
        begin
            best_c   = p_cost;
            choice_c = pcc_pkg::CHOICE_PREV;
            mlen_c   = plen;
        end
    end

    assign total_sum = {1'b0, total_reg} + 21'(best_reg);

    always_comb
    begin
        status.scan_more  = act2 && (ptr_reg < fill_reg);
        status.need2      = act2 && !found2_reg;
        status.need3      = act3 && !found3_reg;
        status.full       = (fill_reg >= cap);
        status.sw_zero    = (rd_data_reg[WW-1:KW] == 2'd0);
        status.pick_cache = (choice_c == pcc_pkg::CHOICE_CACHE);
        status.out_free   = !out_valid_reg || out_ready;
    end

    // Memory port selection
    always_comb
    begin
        rd_en   = cmd.scan_rd || cmd.sw_rd;
        rd_addr = cmd.sw_rd ? hand_eff : ptr_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = hand_reg;
        wr_data = {2'd0, ins_key};
        if (cmd.inc_wr)
        begin
            wr_en = 1'b1;
            if (found3_reg)
            begin
                wr_addr = idx3_reg;
                wr_data = {(sc3_reg == 2'd3) ? 2'd3 : sc3_reg + 2'd1, key3};
            end
            else
            begin
                wr_addr = idx2_reg;
                wr_data = {(sc2_reg == 2'd3) ? 2'd3 : sc2_reg + 2'd1, key2};
            end
        end
        else if (cmd.ins_direct)
        begin
            wr_en   = 1'b1;
            wr_addr = fill_reg[AW-1:0];
        end
        else if (cmd.sw_ev)
        begin
            wr_en = 1'b1;
            if (!status.sw_zero)
                wr_data = {rd_data_reg[WW-1:KW] - 2'd1, rd_data_reg[KW-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        fill_next       = fill_reg;
        hand_next       = hand_reg;
        ptr_next        = ptr_reg;
        prev_valid_next = prev_valid_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        found2_next     = found2_reg;
        found3_next     = found3_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.load)
        begin
            ptr_next    = '0;
            found2_next = 1'b0;
            found3_next = 1'b0;
            if (in_region_start)
            begin
                fill_next       = '0;
                hand_next       = '0;
                prev_valid_next = 1'b0;
                total_next      = '0;
            end
        end
        if (cmd.scan_cmp)
        begin
            ptr_next = ptr_reg + CW'(1);
            if (act3 && !found3_reg && (rd_data_reg[KW-1:0] == key3))
                found3_next = 1'b1;
            if (act2 && !found2_reg && (rd_data_reg[KW-1:0] == key2))
                found2_next = 1'b1;
        end
        if (cmd.ins_direct)
            fill_next = fill_reg + CW'(1);
        if (cmd.sw_rd)
            hand_next = hand_eff;
        if (cmd.sw_ev)
        begin
            hand_next = hand_adv;
            // Overwriting the slot of the long prefix makes it missing again.
            if (status.sw_zero && !cmd.ins_sel3 && found3_reg && (hand_reg == idx3_reg))
                found3_next = 1'b0;
        end
        if (cmd.finish)
        begin
            prev_valid_next = 1'b1;
            total_next      = (total_sum > 21'(pcc_pkg::TOTAL_MAX)) ?
                              pcc_pkg::TOTAL_MAX : total_sum[19:0];
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            hand_reg       <= '0;
            ptr_reg        <= '0;
            prev_valid_reg <= 1'b0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            found2_reg     <= 1'b0;
            found3_reg     <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            hand_reg       <= hand_next;
            ptr_reg        <= ptr_next;
            prev_valid_reg <= prev_valid_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            found2_reg     <= found2_next;
            found3_reg     <= found3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bytes_reg <= in_bytes & pcc_pkg::byte_mask(n_in);
            n_reg     <= n_in;
            if (in_region_start)
            begin
                prev_tok_reg <= '0;
                prev_len_reg <= '0;
            end
        end
        if (cmd.scan_cmp)
        begin
            if (act3 && !found3_reg && (rd_data_reg[KW-1:0] == key3))
            begin
                idx3_reg <= ptr_reg[AW-1:0];
                sc3_reg  <= rd_data_reg[WW-1:KW];
            end
            if (act2 && !found2_reg && (rd_data_reg[KW-1:0] == key2))
            begin
                idx2_reg <= ptr_reg[AW-1:0];
                sc2_reg  <= rd_data_reg[WW-1:KW];
            end
        end
        if (cmd.decide)
        begin
            best_reg   <= best_c;
            choice_reg <= choice_c;
            hit_reg    <= hit_c;
            mlen_reg   <= mlen_c;
        end
        if (cmd.finish)
        begin
            prev_tok_reg <= bytes_reg;
            prev_len_reg <= n_reg;
            o_cost_reg   <= best_reg;
            o_choice_reg <= choice_reg;
            o_hit_reg    <= hit_reg;
            o_mlen_reg   <= mlen_reg;
            o_total_reg  <= total_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_cost   = o_cost_reg;
    assign out_choice = o_choice_reg;
    assign out_hit    = o_hit_reg;
    assign out_mlen   = o_mlen_reg;
    assign out_total  = o_total_reg;

endmodule

`default_nettype wire

// ===== rtl/pcc_checker.sv =====
// Port-level checks for the prefix cache token cost top level, bound to it.
// Depends on prefix_cache_token_cost_top_defines.svh for the assertion macros.
`default_nettype none
`include "prefix_cache_token_cost_top_defines.svh"

module pcc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic        psel,
    input wire logic        pready
);

    logic [33:0] m_beat;
    logic        out_literal;
    logic        out_prev;

    assign m_beat      = {m_tuser, m_tdata};
    assign out_literal = m_tvalid && (m_tuser == pcc_pkg::CHOICE_LITERAL);
    assign out_prev    = m_tvalid && (m_tuser == pcc_pkg::CHOICE_PREV);

    // A beat held back by the sink keeps its contents.
    `PCC_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_beat))
    // The block works on one token at a time after taking a beat.
    `PCC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // A literal carries no match length.
    `PCC_ASSERT_IMP(a_literal_len, clk, rst_n, out_literal, m_tdata[8:7] == 2'd0)
    // A previous-token match always has a real prefix length.
    `PCC_ASSERT_IMP(a_prev_len, clk, rst_n, out_prev, m_tdata[8:7] != 2'd0)
    // The configuration port never inserts wait states.
    `PCC_ASSERT_IMP(a_pready_high, clk, rst_n, psel, pready)

endmodule

bind prefix_cache_token_cost_top pcc_checker u_pcc_checker (.*);

`default_nettype wire
